FILE: hdl/lpht_pkg.sv
// Package for the linear probing hash table.
// Holds field widths, operation, tag and status codes shared by all files.
// No dependencies.
package lpht_pkg;

   // Field widths fixed by the item format.
   localparam int KEY_W    = 31;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 7;
   localparam int TAG_W    = 2;
   localparam int CFG_W    = 8;
   localparam int BIT_W    = 5;

   // APB register file.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CFG_W-1:0] TABLE_SIZE_RST = 8'd128;

   // Request operations.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // Slot tags.
   localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
   localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
   localparam logic [TAG_W-1:0] TAG_GONE  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DELETED  = 3'd4;

endpackage

FILE: hdl/lpht_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on lpht_pkg for the payload widths.
interface lpht_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpht_pkg::OP_W-1:0]     req_type;
   logic [lpht_pkg::KEY_W-1:0]    key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface lpht_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lpht_pkg::STATUS_W-1:0]   status;
   logic [lpht_pkg::SLOT_W-1:0]     slot_index;

   modport source (output valid, output status, output slot_index, input ready);
   modport sink   (input valid, input status, input slot_index, output ready);
endinterface

FILE: hdl/linear_probing_hash_table_top.sv
// Linear probing hash table: top level with sequencer, divider and slot memory.
// Depends on lpht_pkg and the channel interfaces in lpht_if.sv.
//
// Usage:
//   req_chan carries one request per transfer: req_type (insert, search,
//   delete) and a key. rsp_chan returns exactly one result per request:
//   status and slot_index. The csr APB port holds table_size at address 0.
//   One request is in work at a time; req_chan.ready is high only while the
//   sequencer is idle. A request first reduces the key modulo the live table
//   size bit-serially, then probes the slot memory (1 to the live table size
//   probes, one read per cycle on its single read port), then hands the
//   result to the output register; the next request is taken once the
//   sequencer is back in idle. The result register parts the two sides: a
//   new request is taken while a result still waits; if the receiver stalls,
//   the next finished result holds in the sequencer until the output
//   register frees.
//   After reset the block sweeps all slots of the slot memory to empty, one
//   slot per cycle, and takes no request meanwhile. table_size resets to 128.
//   The user must write table_size only while the block is idle; the block
//   itself does not enforce it.
module linear_probing_hash_table_top #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   lpht_req_if.sink                            req_chan,
   lpht_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lpht_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lpht_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [lpht_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W = lpht_pkg::TAG_W + lpht_pkg::KEY_W;
   localparam int KW     = lpht_pkg::KEY_W;

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [lpht_pkg::CFG_W-1:0]       table_size_ff, table_size_in;
   logic [IDX_W-1:0]                 clr_ff, clr_in;
   logic [lpht_pkg::OP_W-1:0]        op_ff, op_in;
   logic [KW-1:0]                    key_ff, key_in;
   logic [lpht_pkg::BIT_W-1:0]       bit_ff, bit_in;
   logic [CNT_W-1:0]                 rem_ff, rem_in;
   logic [IDX_W-1:0]                 pos_ff, pos_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [lpht_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [lpht_pkg::SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lpht_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [lpht_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   // Slot memory: tag over key in each word.
   logic [WORD_W-1:0]                slot_mem [TABLE_DEPTH];
   logic [WORD_W-1:0]                rd_data_ff;
   logic [IDX_W-1:0]                 rd_addr;
   logic                             wr_en;
   logic [IDX_W-1:0]                 wr_addr;
   logic [WORD_W-1:0]                wr_data;

   logic [CNT_W-1:0]                 live_size;
   logic [CNT_W:0]                   rem_shift;
   logic [CNT_W:0]                   rem_diff;
   logic [IDX_W:0]                   pos_inc;
   logic [IDX_W-1:0]                 pos_next;
   logic                             last_probe;
   logic [lpht_pkg::TAG_W-1:0]       rd_tag;
   logic [KW-1:0]                    rd_key;
   logic                             csr_write;
   logic                             req_xfer;
   logic                             rsp_xfer;
   logic                             out_free;

   // Live table size: zero counts as one, large values saturate at the depth.
   always_comb begin
      if (table_size_ff == '0) begin
         live_size = CNT_W'(1);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         live_size = CNT_W'(TABLE_DEPTH);
      end else begin
         live_size = CNT_W'(table_size_ff);
      end
   end

   // APB register access.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & ~csr_paddr[2];
   assign csr_prdata = csr_paddr[2] ? '0 : lpht_pkg::CSR_DATA_W'(table_size_ff);

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_write) begin
         table_size_in = csr_pwdata[lpht_pkg::CFG_W-1:0];
      end
   end

   // Handshakes.
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid & req_chan.ready;
   assign rsp_xfer       = rsp_valid_ff & rsp_chan.ready;
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;

   // Restoring division step: one key bit per cycle into the remainder.
   assign rem_shift = {rem_ff, key_ff[bit_ff]};
   assign rem_diff  = rem_shift - {1'b0, live_size};

   // Next probe position wraps at the live size.
   assign pos_inc    = {1'b0, pos_ff} + 1'b1;
   assign pos_next   = ((CNT_W + 1)'(pos_inc) == (CNT_W + 1)'(live_size)) ? '0
                       : pos_inc[IDX_W-1:0];
   assign last_probe = ((CNT_W + 1)'(cnt_ff) + 1'b1) == {1'b0, live_size};

   assign rd_tag = rd_data_ff[WORD_W-1:KW];
   assign rd_key = rd_data_ff[KW-1:0];

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = '0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {lpht_pkg::TAG_EMPTY, {KW{1'b0}}};
            clr_in  = clr_ff + 1'b1;
            if (32'(clr_ff) == TABLE_DEPTH - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               op_in    = req_chan.req_type;
               key_in   = req_chan.key;
               bit_in   = lpht_pkg::BIT_W'(KW - 1);
               rem_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_diff[CNT_W]) begin
               rem_in = rem_shift[CNT_W-1:0];
            end else begin
               rem_in = rem_diff[CNT_W-1:0];
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               // Home slot is known: start the first read.
               pos_in   = rem_in[IDX_W-1:0];
               rd_addr  = rem_in[IDX_W-1:0];
               cnt_in   = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            // rd_data_ff holds the slot at pos_ff; prefetch the next one.
            rd_addr = pos_next;
            pos_in  = pos_next;
            cnt_in  = cnt_ff + 1'b1;
            case (op_ff)
               lpht_pkg::OP_INSERT: begin
                  if (rd_tag == lpht_pkg::TAG_EMPTY) begin
                     wr_en         = 1'b1;
                     wr_data       = {lpht_pkg::TAG_USED, key_ff};
                     res_status_in = lpht_pkg::STATUS_INSERTED;
                     res_slot_in   = lpht_pkg::SLOT_W'(pos_ff);
                     state_in      = S_OUT;
                  end else if (last_probe) begin
                     res_status_in = lpht_pkg::STATUS_OVERFLOW;
                     res_slot_in   = '0;
                     state_in      = S_OUT;
                  end
               end
               lpht_pkg::OP_SEARCH, lpht_pkg::OP_DELETE: begin
                  if (rd_tag == lpht_pkg::TAG_EMPTY) begin
                     res_status_in = lpht_pkg::STATUS_NOTFOUND;
                     res_slot_in   = '0;
                     state_in      = S_OUT;
                  end else if (rd_tag == lpht_pkg::TAG_USED && rd_key == key_ff) begin
                     res_slot_in = lpht_pkg::SLOT_W'(pos_ff);
                     state_in    = S_OUT;
                     if (op_ff == lpht_pkg::OP_DELETE) begin
                        wr_en         = 1'b1;
                        wr_data       = {lpht_pkg::TAG_GONE, {KW{1'b0}}};
                        res_status_in = lpht_pkg::STATUS_DELETED;
                     end else begin
                        res_status_in = lpht_pkg::STATUS_FOUND;
                     end
                  end else if (last_probe) begin
                     res_status_in = lpht_pkg::STATUS_NOTFOUND;
                     res_slot_in   = '0;
                     state_in      = S_OUT;
                  end
               end
               default: begin
                  // Unused operation code: no change, answers not found.
                  res_status_in = lpht_pkg::STATUS_NOTFOUND;
                  res_slot_in   = '0;
                  state_in      = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register toward the response channel.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         table_size_ff <= lpht_pkg::TABLE_SIZE_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         table_size_ff <= table_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      bit_ff        <= bit_in;
      rem_ff        <= rem_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   // Slot memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // Slot memory read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
   end

endmodule
